// ----- hdl/bfh_pkg.sv -----
// Shared types, constants and the FNV-1a step for the bloom filter hash unit.
package bfh_pkg;

    localparam int HASH_W      = 64;
    localparam int BITS_W      = 17;  // bit_count register width
    localparam int PROBES_W    = 5;   // hash_count register width
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int WORD_W      = 64;  // bits per store word
    localparam int WORD_SEL_W  = 6;   // bit index inside a store word

    // dividend bits consumed per cycle by the modulo unit
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = HASH_W / MOD_BITS_PER_STEP;
    localparam int MOD_CNT_W         = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [HASH_W-1:0] SEED_TWO  = 64'h9E3779B97F4A7C15;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 4'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_MOD,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [BITS_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [BITS_W-1:0] rem;
    } mod_resp_t;

    // One FNV-1a step: xor in the byte, multiply by 2^40 + 0x1B3 modulo 2^64.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ----- hdl/bloom_filter_fnv_double_hash_unit.sv -----
// Bloom filter with double FNV-1a hashing: sequencer, config registers and bit store.
// Key bytes that are not last are taken one per cycle, back to back, while the unit is idle.
// A last byte runs hash_count probes (capped at MAX_PROBES; none if either count is 0),
// each an issue, a modulo by the 4-bit-per-cycle unit, a done and an update step, then hands
// off the result once the output register is free. Reset and every bit_count write start a
// clearing pass of one store word per cycle; no key byte is taken during it.
module bloom_filter_fnv_double_hash_unit #(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bfh_pkg::BYTE_W-1:0]     s_key_byte,
    input  logic                           s_last,
    input  logic                           s_func,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_maybe_present,
    output logic                           m_was_query,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfh_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_WORDS = (MAX_FILTER_BITS + 63) / 64;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    bfh_pkg::state_t state_reg, state_next;

    logic [bfh_pkg::BITS_W-1:0]   bit_count_reg;
    logic [bfh_pkg::PROBES_W-1:0] hash_count_reg;
    logic [bfh_pkg::BITS_W-1:0]   nb_eff;
    logic [bfh_pkg::PROBES_W-1:0] np_eff;

    logic [ADDR_W-1:0]            clr_reg, clr_next;
    logic [bfh_pkg::HASH_W-1:0]   acc_reg, acc_next;
    logic [bfh_pkg::HASH_W-1:0]   step_reg, step_next;
    logic [bfh_pkg::PROBES_W-1:0] idx_reg, idx_next;
    logic                         func_reg, func_next;
    logic                         all_set_reg, all_set_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         present_reg, present_next;
    logic                         query_reg, query_next;

    logic                         s_beat;
    logic                         cfg_beat;
    logic                         out_free;
    logic [bfh_pkg::HASH_W-1:0]   h1_next;
    logic [bfh_pkg::HASH_W-1:0]   h2_next;

    bfh_pkg::mod_req_t            mod_req;
    bfh_pkg::mod_resp_t           mod_resp;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_addr;
    logic [bfh_pkg::WORD_W-1:0]   ram_wdata;
    logic [bfh_pkg::WORD_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]            probe_word;
    logic [bfh_pkg::WORD_W-1:0]   probe_mask;

    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign nb_eff = (32'(bit_count_reg) > 32'(MAX_FILTER_BITS)) ?
                    bfh_pkg::BITS_W'(MAX_FILTER_BITS) : bit_count_reg;
    assign np_eff = (32'(hash_count_reg) > 32'(MAX_PROBES)) ?
                    bfh_pkg::PROBES_W'(MAX_PROBES) : hash_count_reg;

    assign probe_word = ADDR_W'(32'(mod_resp.rem) >> bfh_pkg::WORD_SEL_W);
    assign probe_mask = bfh_pkg::WORD_W'(1) << mod_resp.rem[bfh_pkg::WORD_SEL_W-1:0];

    bfh_fnv u_fnv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_beat),
        .restart  (s_last),
        .key_byte (s_key_byte),
        .h1_next  (h1_next),
        .h2_next  (h2_next)
    );

    bfh_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .resp    (mod_resp)
    );

    bfh_ram #(
        .WIDTH  (bfh_pkg::WORD_W),
        .DEPTH  (STORE_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg  <= '0;
            hash_count_reg <= bfh_pkg::PROBES_W'(1);
        end else if (cfg_beat) begin
            if (cfg_index == bfh_pkg::REG_BIT_COUNT) begin
                bit_count_reg <= cfg_data[bfh_pkg::BITS_W-1:0];
            end else if (cfg_index == bfh_pkg::REG_HASH_COUNT) begin
                hash_count_reg <= cfg_data[bfh_pkg::PROBES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfh_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        func_reg    <= func_next;
        all_set_reg <= all_set_next;
        present_reg <= present_next;
        query_reg   <= query_next;
    end

    always_comb begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        acc_next         = acc_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        func_next        = func_reg;
        all_set_next     = all_set_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        present_next     = present_reg;
        query_next       = query_reg;
        s_ready          = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = acc_reg;
        mod_req.divisor  = nb_eff;
        ram_we           = 1'b0;
        ram_addr         = probe_word;
        ram_wdata        = ram_rdata | probe_mask;

        unique case (state_reg)
            bfh_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_WORDS - 1)) begin
                    clr_next   = '0;
                    state_next = bfh_pkg::ST_IDLE;
                end
            end
            bfh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_beat && s_last) begin
                    acc_next     = h1_next;
                    step_next    = h2_next;
                    idx_next     = '0;
                    func_next    = s_func;
                    all_set_next = 1'b1;
                    if (nb_eff == '0 || np_eff == '0) begin
                        state_next = bfh_pkg::ST_DONE;
                    end else begin
                        state_next = bfh_pkg::ST_PROBE;
                    end
                end
            end
            bfh_pkg::ST_PROBE: begin
                mod_req.start = 1'b1;
                state_next    = bfh_pkg::ST_MOD;
            end
            bfh_pkg::ST_MOD: begin
                // remainder is final when done pulses: issue the word read now
                if (mod_resp.done) begin
                    state_next = bfh_pkg::ST_UPD;
                end
            end
            bfh_pkg::ST_UPD: begin
                if (func_reg) begin
                    all_set_next = all_set_reg &&
                                   ram_rdata[mod_resp.rem[bfh_pkg::WORD_SEL_W-1:0]];
                end else begin
                    ram_we = 1'b1;
                end
                acc_next = acc_reg + step_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == np_eff - 1'b1) begin
                    state_next = bfh_pkg::ST_DONE;
                end else begin
                    state_next = bfh_pkg::ST_PROBE;
                end
            end
            bfh_pkg::ST_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    present_next = func_reg && all_set_reg;
                    query_next   = func_reg;
                    state_next   = bfh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfh_pkg::ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a new filter size restarts the clearing pass
        if (cfg_beat && cfg_index == bfh_pkg::REG_BIT_COUNT) begin
            state_next = bfh_pkg::ST_CLEAR;
            clr_next   = '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_maybe_present = present_reg;
    assign m_was_query     = query_reg;

endmodule

// ----- hdl/bfh_ram.sv -----
// Generic single-port RAM with registered read.
module bfh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/bfh_fnv.sv -----
// Two running FNV-1a hashes over the key bytes, one per seed.
module bfh_fnv (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       restart,
    input  logic [bfh_pkg::BYTE_W-1:0] key_byte,
    output logic [bfh_pkg::HASH_W-1:0] h1_next,
    output logic [bfh_pkg::HASH_W-1:0] h2_next
);

    logic [bfh_pkg::HASH_W-1:0] h1_reg;
    logic [bfh_pkg::HASH_W-1:0] h2_reg;

    assign h1_next = bfh_pkg::fnv_step(h1_reg, key_byte);
    assign h2_next = bfh_pkg::fnv_step(h2_reg, key_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_reg <= bfh_pkg::FNV_BASIS;
            h2_reg <= bfh_pkg::FNV_BASIS ^ bfh_pkg::SEED_TWO;
        end else if (step) begin
            if (restart) begin
                h1_reg <= bfh_pkg::FNV_BASIS;
                h2_reg <= bfh_pkg::FNV_BASIS ^ bfh_pkg::SEED_TWO;
            end else begin
                h1_reg <= h1_next;
                h2_reg <= h2_next;
            end
        end
    end

endmodule

// ----- hdl/bfh_mod.sv -----
// Iterative 64-bit by 17-bit modulo, MOD_BITS_PER_STEP dividend bits per cycle.
module bfh_mod (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfh_pkg::mod_req_t  req,
    output bfh_pkg::mod_resp_t resp
);

    logic [bfh_pkg::HASH_W-1:0]    dvd_reg, dvd_next;
    logic [bfh_pkg::BITS_W-1:0]    dvs_reg;
    logic [bfh_pkg::BITS_W-1:0]    rem_reg, rem_next;
    logic [bfh_pkg::MOD_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    // restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb begin
        logic [bfh_pkg::BITS_W:0]    r;
        logic [bfh_pkg::HASH_W-1:0]  d;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int k = 0; k < bfh_pkg::MOD_BITS_PER_STEP; k++) begin
            r = {r[bfh_pkg::BITS_W-1:0], d[bfh_pkg::HASH_W-1]};
            d = d << 1;
            if (r >= {1'b0, dvs_reg}) begin
                r = r - {1'b0, dvs_reg};
            end
        end
        rem_next = r[bfh_pkg::BITS_W-1:0];
        dvd_next = d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bfh_pkg::MOD_CNT_W'(bfh_pkg::MOD_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign resp.done = done_reg;
    assign resp.rem  = rem_reg;

endmodule
